FILE: rtl/core/pcpa_pkg.sv
package pcpa_pkg;

  localparam int CPU_COUNT_DEF  = 8;
  localparam int PAGE_SHIFT_DEF = 12;
  localparam int MAX_PAGES_DEF  = 32768;

  localparam logic [1:0] MODE_FREE  = 2'd0;
  localparam logic [1:0] MODE_ALLOC = 2'd1;
  localparam logic [1:0] MODE_INIT  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_BADADDR = 2'd2;

  localparam logic CFG_START = 1'b0;
  localparam logic CFG_END   = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_INIT
  } state_t;

  typedef struct packed {
    logic load;
    logic exec_free;
    logic alloc_rd;
    logic alloc_pop;
    logic init_load;
    logic init_push;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       found;
    logic       init_more;
  } stat_t;

endpackage

FILE: rtl/core/per_cpu_page_allocator_unit.sv
// Per-CPU LIFO page allocator over a configured address window. A request is
// taken when start is high and busy is low; its result appears in the first
// cycle that busy is low again, with done high for exactly one cycle, and
// must be captured then since the receiver cannot stall the block. A free is
// busy in S_EXEC only, an alloc that finds a page in S_EXEC and S_POP (one
// link-memory read, then the head update), an alloc that finds every list
// empty in S_EXEC only, and an init in S_EXEC and then S_INIT, which writes
// one link entry per cycle through the single memory write port until the
// window or the link memory is full. Window registers should be written
// only while the block is idle; cfg_ready is always high.
module per_cpu_page_allocator_unit #(
  parameter int CPU_COUNT  = pcpa_pkg::CPU_COUNT_DEF,
  parameter int PAGE_SHIFT = pcpa_pkg::PAGE_SHIFT_DEF,
  parameter int MAX_PAGES  = pcpa_pkg::MAX_PAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [2:0]  cpu,
  input  logic [31:0] page_addr,
  output logic        done,
  output logic [1:0]  status,
  output logic [31:0] alloc_addr,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  pcpa_pkg::cmd_t  cmd;
  pcpa_pkg::stat_t st;

  assign cfg_ready = 1'b1;

  pcpa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  pcpa_dp #(
    .CPU_COUNT  (CPU_COUNT),
    .PAGE_SHIFT (PAGE_SHIFT),
    .MAX_PAGES  (MAX_PAGES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .mode       (mode),
    .cpu        (cpu),
    .page_addr  (page_addr),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .done       (done),
    .status     (status),
    .alloc_addr (alloc_addr)
  );

endmodule

FILE: rtl/core/pcpa_ctrl.sv
module pcpa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  pcpa_pkg::stat_t  st,
  output pcpa_pkg::cmd_t   cmd,
  output logic             busy
);

  pcpa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcpa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      pcpa_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = pcpa_pkg::S_EXEC;
        end
      end
      pcpa_pkg::S_EXEC: begin
        case (st.mode)
          pcpa_pkg::MODE_FREE: begin
            cmd.exec_free = 1'b1;
            cmd.emit      = 1'b1;
            state_next    = pcpa_pkg::S_IDLE;
          end
          pcpa_pkg::MODE_ALLOC: begin
            if (st.found) begin
              cmd.alloc_rd = 1'b1;
              state_next   = pcpa_pkg::S_POP;
            end else begin
              cmd.emit   = 1'b1;
              state_next = pcpa_pkg::S_IDLE;
            end
          end
          pcpa_pkg::MODE_INIT: begin
            cmd.init_load = 1'b1;
            state_next    = pcpa_pkg::S_INIT;
          end
          default: begin
            cmd.emit   = 1'b1;
            state_next = pcpa_pkg::S_IDLE;
          end
        endcase
      end
      pcpa_pkg::S_POP: begin
        cmd.alloc_pop = 1'b1;
        cmd.emit      = 1'b1;
        state_next    = pcpa_pkg::S_IDLE;
      end
      pcpa_pkg::S_INIT: begin
        if (st.init_more) begin
          cmd.init_push = 1'b1;
        end else begin
          cmd.emit   = 1'b1;
          state_next = pcpa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pcpa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/pcpa_dp.sv
module pcpa_dp #(
  parameter int CPU_COUNT  = pcpa_pkg::CPU_COUNT_DEF,
  parameter int PAGE_SHIFT = pcpa_pkg::PAGE_SHIFT_DEF,
  parameter int MAX_PAGES  = pcpa_pkg::MAX_PAGES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  pcpa_pkg::cmd_t   cmd,
  output pcpa_pkg::stat_t  st,
  input  logic [1:0]       mode,
  input  logic [2:0]       cpu,
  input  logic [31:0]      page_addr,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_data,
  output logic             done,
  output logic [1:0]       status,
  output logic [31:0]      alloc_addr
);

  localparam int CPU_W = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam logic [32:0] PAGE_MASK = 33'((64'd1 << PAGE_SHIFT) - 64'd1);
  localparam logic [33:0] PAGE_SIZE = 34'(64'd1 << PAGE_SHIFT);
  localparam logic [32:0] MAX_P33   = 33'(MAX_PAGES);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAGES);
  localparam logic [4:0] CPU_N = 5'(CPU_COUNT);

  logic [31:0] start_addr, end_addr;
  logic [32:0] base;

  logic [1:0]       mode_q;
  logic [CPU_W-1:0] cpu_q;
  logic [31:0]      pa_q;

  logic             hv   [CPU_COUNT];
  logic [IDX_W-1:0] hidx [CPU_COUNT];

  logic [IDX_W:0]   link_mem [MAX_PAGES];
  logic [IDX_W:0]   mem_rdata;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W:0]   mem_wdata;

  logic [CPU_W-1:0] sel, sel_q, rd_cpu;
  logic             found;
  logic [IDX_W-1:0] pop_idx;
  logic [CNT_W-1:0] cnt;
  logic [33:0]      p_next;

  logic [4:0]       cpu_wrap;
  logic [32:0]      diff, fidx_full;
  logic             bad;
  logic [32:0]      pop_addr;

  // config registers and rounded-up base
  always_ff @(posedge clk) begin
    if (rst) begin
      start_addr <= '0;
      end_addr   <= '0;
      base       <= '0;
    end else if (cfg_we) begin
      if (cfg_index == pcpa_pkg::CFG_START) begin
        start_addr <= cfg_data;
        base       <= ({1'b0, cfg_data} + PAGE_MASK) & ~PAGE_MASK;
      end else begin
        end_addr <= cfg_data;
      end
    end
  end

  // cpu wrapped into range
  always_comb begin
    cpu_wrap = {2'b00, cpu};
    for (int k = 0; k < 8; k++) begin
      if (cpu_wrap >= CPU_N) begin
        cpu_wrap = cpu_wrap - CPU_N;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= mode;
      cpu_q  <= cpu_wrap[CPU_W-1:0];
      pa_q   <= page_addr;
    end
  end

  // victim list: own first, else lowest other non-empty list
  always_comb begin
    sel   = cpu_q;
    found = 1'b0;
    for (int i = CPU_COUNT - 1; i >= 0; i--) begin
      if (hv[i] && (CPU_W'(i) != cpu_q)) begin
        sel   = CPU_W'(i);
        found = 1'b1;
      end
    end
    if (hv[cpu_q]) begin
      sel   = cpu_q;
      found = 1'b1;
    end
  end

  assign rd_cpu = cmd.alloc_rd ? sel : cpu_q;

  // free address check
  assign diff      = {1'b0, pa_q} - base;
  assign fidx_full = diff >> PAGE_SHIFT;
  assign bad       = (pa_q & PAGE_MASK[31:0]) != '0 || pa_q < start_addr ||
                     pa_q >= end_addr || fidx_full >= MAX_P33;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fidx_full[IDX_W-1:0];
    mem_wdata = {hv[rd_cpu], hidx[rd_cpu]};
    if (cmd.exec_free && !bad) begin
      mem_we = 1'b1;
    end else if (cmd.init_push) begin
      mem_we    = 1'b1;
      mem_waddr = cnt[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.alloc_rd) begin
      mem_rdata <= link_mem[hidx[rd_cpu]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CPU_COUNT; i++) begin
        hv[i] <= 1'b0;
      end
    end else begin
      if (cmd.exec_free && !bad) begin
        hv[cpu_q]   <= 1'b1;
        hidx[cpu_q] <= fidx_full[IDX_W-1:0];
      end else if (cmd.init_push) begin
        hv[cpu_q]   <= 1'b1;
        hidx[cpu_q] <= cnt[IDX_W-1:0];
      end else if (cmd.alloc_pop) begin
        hv[sel_q]   <= mem_rdata[IDX_W];
        hidx[sel_q] <= mem_rdata[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc_rd) begin
      sel_q   <= sel;
      pop_idx <= hidx[rd_cpu];
    end
    if (cmd.init_load) begin
      cnt    <= '0;
      p_next <= {1'b0, base} + PAGE_SIZE;
    end else if (cmd.init_push) begin
      cnt    <= cnt + CNT_W'(1);
      p_next <= p_next + PAGE_SIZE;
    end
  end

  assign pop_addr = base + (33'(pop_idx) << PAGE_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (cmd.alloc_pop) begin
        status     <= pcpa_pkg::ST_OK;
        alloc_addr <= pop_addr[31:0];
      end else begin
        alloc_addr <= '0;
        if (mode_q == pcpa_pkg::MODE_FREE) begin
          status <= bad ? pcpa_pkg::ST_BADADDR : pcpa_pkg::ST_OK;
        end else if (mode_q == pcpa_pkg::MODE_ALLOC) begin
          status <= pcpa_pkg::ST_EMPTY;
        end else begin
          status <= pcpa_pkg::ST_OK;
        end
      end
    end
  end

  assign st.mode      = mode_q;
  assign st.found     = found;
  assign st.init_more = (cnt < MAX_CNT) && (p_next <= {2'b00, end_addr});

  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("back-to-back result beats");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == pcpa_pkg::ST_OK || status == pcpa_pkg::ST_EMPTY ||
              status == pcpa_pkg::ST_BADADDR)) else $error("bad status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != pcpa_pkg::ST_OK |-> alloc_addr == '0)
    else $error("address on failed request");

  a_pop_result: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc_pop |=> done && status == pcpa_pkg::ST_OK)
    else $error("pop without ok result");

endmodule
